[hw/rtl/qmr_pkg.sv]
// shared constants, op codes and hamilton product tables for the quaternion core
package qmr_pkg;

    typedef enum logic {
        OP_MULTIPLY = 1'b0,
        OP_ROTATE   = 1'b1
    } t_op;

    // largest normalized magnitude lands in [2^29, 2^30)
    localparam int NORM_W  = 30;
    localparam int RAD_W   = 2 * NORM_W + 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int CHUNK_W = 8;

    // right operand index for each output component and term
    localparam logic [1:0] HAM_RIGHT [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    // term is subtracted from the component sum
    localparam logic HAM_SUB [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0}
    };

endpackage

[hw/rtl/quaternion_multiply_rotate_core.sv]
// top level: hamilton product or rotation, two unit-product stages in series
// throughput: one item per cycle, busy stays low outside reset
// latency set by the one-bit-per-stage square root and the per-lane dividers
// each result shows for one cycle with o_valid, the receiver cannot stall
// reset is synchronous active low, clears all valid flags, busy is high while in reset
module quaternion_multiply_rotate_core #(
    parameter int COMPONENT_WIDTH = 18,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic signed [COMPONENT_WIDTH-1:0] i_left_w,
    input  logic signed [COMPONENT_WIDTH-1:0] i_left_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_left_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_left_z,
    input  logic signed [COMPONENT_WIDTH-1:0] i_right_w,
    input  logic signed [COMPONENT_WIDTH-1:0] i_right_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_right_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_right_z,
    output logic                              o_valid,
    output logic signed [COMPONENT_WIDTH-1:0] o_out_w,
    output logic signed [COMPONENT_WIDTH-1:0] o_out_x,
    output logic signed [COMPONENT_WIDTH-1:0] o_out_y,
    output logic signed [COMPONENT_WIDTH-1:0] o_out_z,
    output logic                              o_degenerate
);
    localparam int W       = COMPONENT_WIDTH;
    localparam int F       = FRACTION_BITS;
    localparam int IW      = W + 1;
    localparam int LATENCY = 2 * F + 90;

    typedef struct packed {
        qmr_pkg::t_op      op;
        logic              zvec;
        logic [3:0][W-1:0] left;
        logic [2:0][W-1:0] vec;
    } t_tag_a;

    typedef struct packed {
        qmr_pkg::t_op      op;
        logic              zvec;
        logic              zero_a;
        logic [3:0][W-1:0] mid;
        logic [2:0][W-1:0] vec;
    } t_tag_b;

    localparam int TWA = $bits(t_tag_a);
    localparam int TWB = $bits(t_tag_b);

    logic                r_v0;
    qmr_pkg::t_op        r_op;
    logic signed [W-1:0] r_left  [4];
    logic signed [W-1:0] r_right [4];

    logic                zvec;
    logic signed [W:0]   a_a [4];
    logic signed [W:0]   b_a [4];
    t_tag_a              tag_a_in;
    t_tag_a              tag_a_out;
    logic [TWA-1:0]      tag_a_vec;
    logic                va;
    logic signed [W-1:0] res_a [4];
    logic                zero_a;

    logic signed [W:0]   a_b [4];
    logic signed [W:0]   b_b [4];
    t_tag_b              tag_b_in;
    t_tag_b              tag_b_out;
    logic [TWB-1:0]      tag_b_vec;
    logic                vb;
    logic signed [W-1:0] res_b [4];
    logic                zero_b;

    logic signed [W-1:0] n_out [4];
    logic                n_degen;
    logic                r_vo;
    logic signed [W-1:0] r_out [4];
    logic                r_degen;

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_vo <= vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op       <= qmr_pkg::t_op'(i_operation);
            r_left[0]  <= i_left_w;
            r_left[1]  <= i_left_x;
            r_left[2]  <= i_left_y;
            r_left[3]  <= i_left_z;
            r_right[0] <= i_right_w;
            r_right[1] <= i_right_x;
            r_right[2] <= i_right_y;
            r_right[3] <= i_right_z;
        end
    end

    assign zvec = (r_right[1] == '0) && (r_right[2] == '0) && (r_right[3] == '0);

    // first product: left*right, or v*conj(q) for rotate
    always_comb begin
        tag_a_in.op   = r_op;
        tag_a_in.zvec = zvec;
        for (int i = 0; i < 4; i++) begin
            tag_a_in.left[i] = r_left[i];
        end
        for (int i = 0; i < 3; i++) begin
            tag_a_in.vec[i] = r_right[i+1];
        end
        if (r_op == qmr_pkg::OP_ROTATE) begin
            a_a[0] = '0;
            b_a[0] = IW'(r_left[0]);
            for (int i = 1; i < 4; i++) begin
                a_a[i] = IW'(r_right[i]);
                b_a[i] = -IW'(r_left[i]);
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                a_a[i] = IW'(r_left[i]);
                b_a[i] = IW'(r_right[i]);
            end
        end
    end

    assign tag_a_vec = tag_a_in;

    qmr_unit #(
        .W  (W),
        .F  (F),
        .TW (TWA)
    ) u_unit_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_a     (a_a),
        .i_b     (b_a),
        .i_tag   (tag_a_vec),
        .o_valid (va),
        .o_res   (res_a),
        .o_zero  (zero_a),
        .o_tag   (tag_a_out)
    );

    // second product: q*t for rotate, ignored for multiply
    always_comb begin
        tag_b_in.op     = tag_a_out.op;
        tag_b_in.zvec   = tag_a_out.zvec;
        tag_b_in.zero_a = zero_a;
        tag_b_in.vec    = tag_a_out.vec;
        for (int i = 0; i < 4; i++) begin
            tag_b_in.mid[i] = res_a[i];
            a_b[i] = IW'(signed'(tag_a_out.left[i]));
            b_b[i] = IW'(res_a[i]);
        end
    end

    assign tag_b_vec = tag_b_in;

    qmr_unit #(
        .W  (W),
        .F  (F),
        .TW (TWB)
    ) u_unit_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (va),
        .i_a     (a_b),
        .i_b     (b_b),
        .i_tag   (tag_b_vec),
        .o_valid (vb),
        .o_res   (res_b),
        .o_zero  (zero_b),
        .o_tag   (tag_b_out)
    );

    always_comb begin
        n_degen = 1'b0;
        n_out[0] = '0;
        for (int i = 1; i < 4; i++) begin
            n_out[i] = '0;
        end
        if (tag_b_out.op == qmr_pkg::OP_MULTIPLY) begin
            for (int i = 0; i < 4; i++) begin
                n_out[i] = tag_b_out.mid[i];
            end
            n_degen = tag_b_out.zero_a;
        end else if (tag_b_out.zvec) begin
            // zero vector passes through
            for (int i = 1; i < 4; i++) begin
                n_out[i] = tag_b_out.vec[i-1];
            end
        end else if (tag_b_out.zero_a || zero_b) begin
            n_degen = 1'b1;
        end else begin
            for (int i = 1; i < 4; i++) begin
                n_out[i] = res_b[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_out[i] <= n_out[i];
        end
        r_degen <= n_degen;
    end

    assign o_valid      = r_vo;
    assign o_out_w      = r_out[0];
    assign o_out_x      = r_out[1];
    assign o_out_y      = r_out[2];
    assign o_out_z      = r_out[3];
    assign o_degenerate = r_degen;

endmodule

[hw/rtl/qmr_isqrt.sv]
// pipelined integer square root, one root bit per stage, shared by the four lanes
module qmr_isqrt #(
    parameter int TW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [qmr_pkg::RAD_W-1:0]   i_rad,
    input  logic [TW-1:0]               i_tag,
    output logic                        o_valid,
    output logic [qmr_pkg::ROOT_W-1:0]  o_root,
    output logic [TW-1:0]               o_tag
);
    localparam int SW = qmr_pkg::RAD_W;
    localparam int RW = qmr_pkg::ROOT_W;
    localparam int EW = RW + 3;

    logic [RW:0]   r_vld;
    logic [SW-1:0] r_rad  [RW+1];
    logic [EW-1:0] r_rem  [RW+1];
    logic [RW-1:0] r_root [RW+1];
    logic [TW-1:0] r_tag  [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[RW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_tag[0]  <= i_tag;
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [EW-1:0] rem_sh;
        logic [EW-1:0] trial;

        // bring down the next bit pair, try root*4+1
        assign rem_sh = {r_rem[k][EW-3:0], r_rad[k][SW-1-2*k -: 2]};
        assign trial  = {1'b0, r_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            r_rad[k+1] <= r_rad[k];
            r_tag[k+1] <= r_tag[k];
            if (rem_sh >= trial) begin
                r_rem[k+1]  <= rem_sh - trial;
                r_root[k+1] <= {r_root[k][RW-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= rem_sh;
                r_root[k+1] <= {r_root[k][RW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[RW];
    assign o_root  = r_root[RW];
    assign o_tag   = r_tag[RW];

endmodule

[hw/rtl/qmr_div.sv]
// pipelined restoring divider for one lane, one quotient bit per stage
module qmr_div #(
    parameter int F  = 16,
    parameter int TW = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [F+qmr_pkg::ROOT_W:0]    i_num,
    input  logic [qmr_pkg::ROOT_W:0]      i_den,
    input  logic [TW-1:0]                 i_tag,
    output logic                          o_valid,
    output logic [F:0]                    o_quo,
    output logic [TW-1:0]                 o_tag
);
    localparam int NW = F + qmr_pkg::ROOT_W + 1;
    localparam int DW = qmr_pkg::ROOT_W + 1;
    localparam int QW = F + 1;

    logic [QW:0]   r_vld;
    logic [NW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [TW-1:0] r_tag [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_tag[0] <= i_tag;
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [NW-1:0] trial;

        assign trial = NW'(r_den[k]) << (F - k);

        always_ff @(posedge i_clk) begin
            r_den[k+1] <= r_den[k];
            r_tag[k+1] <= r_tag[k];
            if (r_rem[k] >= trial) begin
                r_rem[k+1] <= r_rem[k] - trial;
                r_quo[k+1] <= {r_quo[k][QW-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_quo[k+1] <= {r_quo[k][QW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_quo[QW];
    assign o_tag   = r_tag[QW];

endmodule

[hw/rtl/qmr_unit.sv]
// unit-length hamilton product: four component lanes, shared norm merge, per-lane divide
module qmr_unit #(
    parameter int W  = 18,
    parameter int F  = 16,
    parameter int TW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W:0]   i_a [4],
    input  logic signed [W:0]   i_b [4],
    input  logic [TW-1:0]       i_tag,
    output logic                o_valid,
    output logic signed [W-1:0] o_res [4],
    output logic                o_zero,
    output logic [TW-1:0]       o_tag
);
    localparam int IW   = W + 1;
    localparam int PW   = 2 * IW;
    localparam int AW   = PW + 2;
    localparam int MW   = AW - 1;
    localparam int CH   = qmr_pkg::CHUNK_W;
    localparam int NC   = (MW + CH - 1) / CH;
    localparam int PADW = NC * CH;
    localparam int CLW  = $clog2(CH + 1);
    localparam int LW   = $clog2(MW + 1);
    localparam int DW   = qmr_pkg::NORM_W;
    localparam int SQW  = 2 * DW;
    localparam int SW   = qmr_pkg::RAD_W;
    localparam int RW   = qmr_pkg::ROOT_W;
    localparam int NW   = F + RW + 1;
    localparam int QW   = F + 1;
    localparam int STW  = ((F + 2 > W) ? F + 2 : W) + 1;
    localparam int PAYW = TW + 5 + 4 * DW;
    localparam int LTW  = TW + 2;
    localparam logic signed [STW-1:0] MAXV = STW'({(W-1){1'b1}});
    localparam logic signed [STW-1:0] MINV = -MAXV - STW'(1);

    logic [8:0]             r_vld;
    logic [TW-1:0]          r_tag [9];
    logic signed [PW-1:0]   r_prod [4][4];
    logic signed [AW-1:0]   r_acc [4];
    logic [MW-1:0]          r_mag3 [4];
    logic [MW-1:0]          r_mag4 [4];
    logic [MW-1:0]          r_mag5 [4];
    logic [MW-1:0]          r_mag6 [4];
    logic [3:0]             r_neg3, r_neg4, r_neg5, r_neg6, r_neg7, r_neg8, r_neg9;
    logic [MW-1:0]          r_orv;
    logic [CLW-1:0]         r_chl [NC];
    logic [LW-1:0]          r_len;
    logic [DW-1:0]          r_d7 [4];
    logic [DW-1:0]          r_d8 [4];
    logic [DW-1:0]          r_d9 [4];
    logic                   r_zero7, r_zero8, r_zero9;
    logic [SQW-1:0]         r_sq [4];
    logic [SW-1:0]          r_sum;

    logic signed [AW-1:0]   n_acc [4];
    logic signed [AW-1:0]   n_abs [4];
    logic [PADW-1:0]        orv_pad;
    logic [CLW-1:0]         n_chl [NC];
    logic [LW-1:0]          n_len;
    logic [MW+DW-1:0]       n_shf [4];

    logic [PAYW-1:0]        sq_pay_in;
    logic [PAYW-1:0]        sq_pay_out;
    logic                   sq_valid;
    logic [RW-1:0]          sq_root;
    logic [DW-1:0]          sq_d [4];
    logic [3:0]             sq_neg;
    logic                   sq_zero;
    logic [TW-1:0]          sq_tag;

    logic [NW-1:0]          div_num [4];
    logic [RW:0]            div_den;
    logic [LTW-1:0]         div_tag [4];
    logic [3:0]             div_valid;
    logic [QW-1:0]          div_quo [4];
    logic [LTW-1:0]         div_otag [4];

    logic signed [STW-1:0]  n_sv [4];
    logic signed [W-1:0]    n_res [4];

    logic                   r_vo;
    logic signed [W-1:0]    r_res [4];
    logic                   r_zo;
    logic [TW-1:0]          r_to;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_vo  <= 1'b0;
        end else begin
            r_vld <= {r_vld[7:0], i_valid};
            r_vo  <= &div_valid;
        end
    end

    // component sums with the hamilton signs applied
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_acc[c] = '0;
            for (int t = 0; t < 4; t++) begin
                if (qmr_pkg::HAM_SUB[c][t]) begin
                    n_acc[c] = n_acc[c] - AW'(r_prod[c][t]);
                end else begin
                    n_acc[c] = n_acc[c] + AW'(r_prod[c][t]);
                end
            end
            n_abs[c] = r_acc[c][AW-1] ? -r_acc[c] : r_acc[c];
        end
    end

    // bit length of the largest magnitude equals that of the or of all four
    assign orv_pad = PADW'(r_orv);

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_chl[c] = '0;
            for (int j = 0; j < CH; j++) begin
                if (orv_pad[c*CH+j]) begin
                    n_chl[c] = CLW'(j + 1);
                end
            end
        end
        n_len = '0;
        for (int c = 0; c < NC; c++) begin
            if (r_chl[c] != '0) begin
                n_len = LW'(c * CH) + LW'(r_chl[c]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            n_shf[c] = {r_mag6[c], {DW{1'b0}}} >> r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        for (int s = 1; s < 9; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
        for (int c = 0; c < 4; c++) begin
            for (int t = 0; t < 4; t++) begin
                r_prod[c][t] <= i_a[t] * i_b[qmr_pkg::HAM_RIGHT[c][t]];
            end
            r_acc[c]  <= n_acc[c];
            r_mag3[c] <= n_abs[c][MW-1:0];
            r_neg3[c] <= r_acc[c][AW-1];
            r_mag4[c] <= r_mag3[c];
            r_mag5[c] <= r_mag4[c];
            r_mag6[c] <= r_mag5[c];
            r_d7[c]   <= n_shf[c][DW-1:0];
            r_sq[c]   <= r_d7[c] * r_d7[c];
            r_d8[c]   <= r_d7[c];
            r_d9[c]   <= r_d8[c];
        end
        r_orv <= r_mag3[0] | r_mag3[1] | r_mag3[2] | r_mag3[3];
        for (int c = 0; c < NC; c++) begin
            r_chl[c] <= n_chl[c];
        end
        r_len   <= n_len;
        r_zero7 <= (r_len == '0);
        r_zero8 <= r_zero7;
        r_zero9 <= r_zero8;
        r_neg4  <= r_neg3;
        r_neg5  <= r_neg4;
        r_neg6  <= r_neg5;
        r_neg7  <= r_neg6;
        r_neg8  <= r_neg7;
        r_neg9  <= r_neg8;
        r_sum   <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]) + SW'(r_sq[3]);
    end

    assign sq_pay_in = {r_tag[8], r_zero9, r_neg9, r_d9[3], r_d9[2], r_d9[1], r_d9[0]};

    qmr_isqrt #(
        .TW(PAYW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[8]),
        .i_rad   (r_sum),
        .i_tag   (sq_pay_in),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_tag   (sq_pay_out)
    );

    assign {sq_tag, sq_zero, sq_neg, sq_d[3], sq_d[2], sq_d[1], sq_d[0]} = sq_pay_out;
    assign div_den = {sq_root, 1'b0};

    for (genvar c = 0; c < 4; c++) begin : g_lane
        // round half away: (d * 2^(f+1) + r) / (2r)
        assign div_num[c] = (NW'(sq_d[c]) << (F + 1)) + NW'(sq_root);
        assign div_tag[c] = {sq_tag, sq_zero, sq_neg[c]};

        qmr_div #(
            .F  (F),
            .TW (LTW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid),
            .i_num   (div_num[c]),
            .i_den   (div_den),
            .i_tag   (div_tag[c]),
            .o_valid (div_valid[c]),
            .o_quo   (div_quo[c]),
            .o_tag   (div_otag[c])
        );
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_sv[c] = STW'(div_quo[c]);
            if (div_otag[c][0]) begin
                n_sv[c] = -n_sv[c];
            end
            if (div_otag[0][1]) begin
                n_res[c] = '0;
            end else if (n_sv[c] > MAXV) begin
                n_res[c] = MAXV[W-1:0];
            end else if (n_sv[c] < MINV) begin
                n_res[c] = MINV[W-1:0];
            end else begin
                n_res[c] = n_sv[c][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_res[c] <= n_res[c];
        end
        r_zo <= div_otag[0][1];
        r_to <= div_otag[0][LTW-1:2];
    end

    assign o_valid = r_vo;
    assign o_res   = r_res;
    assign o_zero  = r_zo;
    assign o_tag   = r_to;

endmodule

[hw/rtl/qmr_checker.sv]
// port-level checks for the quaternion core, bound to the top level
module qmr_checker #(
    parameter int W       = 18,
    parameter int LATENCY = 122
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic signed [W-1:0] o_out_w,
    input logic signed [W-1:0] o_out_x,
    input logic signed [W-1:0] o_out_y,
    input logic signed [W-1:0] o_out_z,
    input logic                o_degenerate
);

    // every accepted beat comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted beat did not produce a result");

    // no result without a matching accept
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted beat");

    // degenerate results are all zero
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_out_w == '0 && o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("degenerate result not zero");

endmodule

bind quaternion_multiply_rotate_core qmr_checker #(
    .W       (COMPONENT_WIDTH),
    .LATENCY (LATENCY)
) u_qmr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_out_w      (o_out_w),
    .o_out_x      (o_out_x),
    .o_out_y      (o_out_y),
    .o_out_z      (o_out_z),
    .o_degenerate (o_degenerate)
);
